// ----- sv/matrix_keypad_debouncer_top_macros.svh -----
// Assertion macros for the keypad debouncer; aclk and aresetn must be in scope.
`ifndef MATRIX_KEYPAD_DEBOUNCER_TOP_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCER_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MKD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keypad debouncer check failed");

// Check that a condition implies another in the next cycle.
`define MKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keypad debouncer check failed");

`endif

// ----- sv/mkd_pkg.sv -----
// Package with widths, codes and reset values for the keypad debouncer.
`default_nettype none
package mkd_pkg;
    localparam int SCAN_BITS = 30;
    localparam int KEY_W     = 5;
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 8;
    localparam int DEF_ROWS  = 5;
    localparam int DEF_COLS  = 6;

    localparam logic [KEY_W-1:0] NO_KEY     = 5'd0;
    localparam logic [KEY_W-1:0] MULTI_CODE = 5'd31;

    localparam logic [CNT_W-1:0] DEF_PRESS_COUNT   = 8'd8;
    localparam logic [CNT_W-1:0] DEF_RELEASE_COUNT = 8'd30;

    localparam logic [IDX_W-1:0] REG_PRESS_COUNT   = 8'd0;
    localparam logic [IDX_W-1:0] REG_RELEASE_COUNT = 8'd1;
endpackage
`default_nettype wire

// ----- sv/matrix_keypad_debouncer_top.sv -----
// An accepted scan is held in the input register and moves to the result register on m_* once that is free.
// Throughput: one scan per cycle while m_ready keeps the result register free; set by the single debounce state update.
// The input register and result register let a scan enter while a result waits.
// Reset (aresetn low, synchronous): run state and lock clear, no event pending,
// press_count returns to 8 and release_count to 30.
`default_nettype none
`include "matrix_keypad_debouncer_top_macros.svh"
module matrix_keypad_debouncer_top #(
    parameter int ROWS = mkd_pkg::DEF_ROWS,
    parameter int COLS = mkd_pkg::DEF_COLS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [mkd_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [mkd_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [mkd_pkg::SCAN_BITS-1:0] s_pressed_bits,
    input  wire logic                         s_ack_event,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [mkd_pkg::KEY_W-1:0]          m_settled_key,
    output logic                              m_event_pending,
    output logic [mkd_pkg::KEY_W-1:0]          m_event_key
);
    localparam int MATRIX_KEYS = (ROWS * COLS >= mkd_pkg::SCAN_BITS) ?
                                 mkd_pkg::SCAN_BITS : ROWS * COLS;

    // configuration
    logic [mkd_pkg::CNT_W-1:0] press_count_reg, release_count_reg;

    // input stage
    logic                          s1_valid_reg;
    logic [mkd_pkg::SCAN_BITS-1:0] s1_bits_reg;
    logic                          s1_ack_reg;

    // debounce state
    logic [mkd_pkg::KEY_W-1:0] cand_reg, cand_next;
    logic [mkd_pkg::CNT_W-1:0] run_reg, run_next;
    logic [mkd_pkg::KEY_W-1:0] cur_key_reg, cur_key_next;
    logic                      lock_reg, lock_next;
    logic [mkd_pkg::KEY_W-1:0] pend_key_reg, pend_key_next, pend_report;

    // result stage
    logic                      m_valid_reg;
    logic [mkd_pkg::KEY_W-1:0] settled_key_reg, event_key_reg;
    logic                      event_pending_reg;

    logic                          advance;
    logic [mkd_pkg::SCAN_BITS-1:0] scan_masked;
    logic [mkd_pkg::KEY_W-1:0]     onehot_key, raw_code;
    logic [mkd_pkg::CNT_W-1:0]     need, run_inc;

    assign advance   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_settled_key   = settled_key_reg;
    assign m_event_pending = event_pending_reg;
    assign m_event_key     = event_key_reg;

    // Write configuration registers; ignore unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_count_reg   <= mkd_pkg::DEF_PRESS_COUNT;
            release_count_reg <= mkd_pkg::DEF_RELEASE_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mkd_pkg::REG_PRESS_COUNT:   press_count_reg   <= cfg_data;
                mkd_pkg::REG_RELEASE_COUNT: release_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the scan transaction in the input register until it advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_bits_reg <= s_pressed_bits;
            s1_ack_reg  <= s_ack_event;
        end
    end

    // Encode the scan: mask off-matrix bits; none set gives NO_KEY, several MULTI_CODE, one its key number.
    always_comb begin
        scan_masked = '0;
        onehot_key  = mkd_pkg::NO_KEY;
        for (int i = 0; i < mkd_pkg::SCAN_BITS; i++) begin
            scan_masked[i] = s1_bits_reg[i] && (i < MATRIX_KEYS);
            if (scan_masked[i]) begin
                onehot_key = onehot_key | mkd_pkg::KEY_W'(i + 1);
            end
        end
        if (scan_masked == '0) begin
            raw_code = mkd_pkg::NO_KEY;
        end else if ((scan_masked & (scan_masked - 1'b1)) != '0) begin
            raw_code = mkd_pkg::MULTI_CODE;
        end else begin
            raw_code = onehot_key;
        end
    end

    // Debounce: count the run, then latch a press or a release.
    always_comb begin
        cand_next    = cand_reg;
        run_next     = run_reg;
        cur_key_next = cur_key_reg;
        lock_next    = lock_reg;
        pend_report  = pend_key_reg;
        need         = (cand_reg == mkd_pkg::NO_KEY) ? release_count_reg : press_count_reg;
        run_inc      = (run_reg < need) ? run_reg + 1'b1 : run_reg;
        if (raw_code != cand_reg) begin
            cand_next = raw_code;
            run_next  = 8'd1;
        end else begin
            run_next = run_inc;
            if (run_inc >= need) begin
                if (cand_reg == mkd_pkg::NO_KEY) begin
                    cur_key_next = mkd_pkg::NO_KEY;
                    lock_next    = 1'b0;
                end else if (cand_reg != mkd_pkg::MULTI_CODE && !lock_reg &&
                             cur_key_reg != cand_reg) begin
                    cur_key_next = cand_reg;
                    pend_report  = cand_reg;
                    lock_next    = 1'b1;
                end
            end
        end
        pend_key_next = s1_ack_reg ? mkd_pkg::NO_KEY : pend_report;
    end

    // Advance debounce state once per scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg     <= mkd_pkg::NO_KEY;
            run_reg      <= '0;
            cur_key_reg  <= mkd_pkg::NO_KEY;
            lock_reg     <= 1'b0;
            pend_key_reg <= mkd_pkg::NO_KEY;
        end else if (advance) begin
            cand_reg     <= cand_next;
            run_reg      <= run_next;
            cur_key_reg  <= cur_key_next;
            lock_reg     <= lock_next;
            pend_key_reg <= pend_key_next;
        end
    end

    // Load the result register; drop valid once the transaction is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            settled_key_reg   <= cur_key_next;
            event_pending_reg <= (pend_report != mkd_pkg::NO_KEY);
            event_key_reg     <= pend_report;
        end
    end

    // Lock is set exactly while a key is latched.
    `MKD_ASSERT_NOW(lock_matches_key, 1'b1, lock_reg == (cur_key_reg != mkd_pkg::NO_KEY))
    // A multiple-key code never latches as the current key.
    `MKD_ASSERT_NOW(no_multi_latch, 1'b1, cur_key_reg != mkd_pkg::MULTI_CODE)
    // A stalled scan stays in the input register.
    `MKD_ASSERT_NEXT(stall_holds_scan, s1_valid_reg && !advance, s1_valid_reg)
    // The pending flag agrees with the event key in every result.
    `MKD_ASSERT_NOW(event_flag_matches, m_valid_reg,
                    event_pending_reg == (event_key_reg != mkd_pkg::NO_KEY))
endmodule
`default_nettype wire
